// ===== src/tvc_pkg.sv =====
// Shared types and codes for the keyed-tableau Vigenere cipher block.
`timescale 1ns / 1ps

package tvc_pkg;

	// Request kinds carried on the input tuser
	typedef enum logic [1:0] {
		CMD_TEXT    = 2'd0,
		CMD_TABLEAU = 2'd1,
		CMD_KEY     = 2'd2
	} cmd_t;

	// Configuration register indexes
	typedef enum logic {
		REG_MODE    = 1'b0,
		REG_KEY_LEN = 1'b1
	} reg_idx_t;

	// Text request sequencer
	typedef enum logic [1:0] {
		S_IDLE,
		S_KEY,
		S_SCAN,
		S_FETCH
	} state_t;

	localparam int unsigned SYM_W     = 8;
	localparam int unsigned KEY_LEN_W = 5;

endpackage

// ===== src/tableau_vigenere_cipher.sv =====
// Keyed-tableau Vigenere cipher: tableau and key memories with a scanning sequencer.
`timescale 1ns / 1ps

// Streams text bytes through a loaded tableau of ALPHABET_SIZE rows by ALPHABET_SIZE
// bytes. A text request ends early when no row header matches its key byte, and
// otherwise runs until its symbol matches in the scanned row or the row is used up;
// its length is set by the single read port of the tableau memory, which steps
// through one column of the scanned row per cycle. Row headers (column 0) are
// mirrored in registers and matched combinationally. Requests are taken one at a
// time; a finished result waits in the output register while the next request is
// accepted. Tableau and key memories have no reset and no clearing pass: text may
// only use entries already written.
module tableau_vigenere_cipher
	import tvc_pkg::*;
#(
	parameter int ALPHABET_SIZE = 26,
	parameter int KEY_MAX       = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // row_index[4:0], column_index[9:5], key_index[13:10],
	                                   // symbol_value[21:14], zero fill [23:22]
	input  logic [1:0]  s_axis_tuser,  // command[1:0]
	input  logic        s_axis_tlast,  // last_of_message
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // result_symbol[7:0]
	output logic        m_axis_tlast,  // result_last
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data
);

	localparam int RW   = $clog2(ALPHABET_SIZE);
	localparam int AW   = $clog2(ALPHABET_SIZE * ALPHABET_SIZE);
	localparam int TD   = ALPHABET_SIZE * ALPHABET_SIZE;
	localparam int KPW  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int RCW  = ($clog2(ALPHABET_SIZE + 1) > 5) ? $clog2(ALPHABET_SIZE + 1) : 5;
	localparam int KCW  = ($clog2(KEY_MAX + 1) > 5) ? $clog2(KEY_MAX + 1) : 5;

	// input field unpacking
	cmd_t             cmd;
	logic [4:0]       in_row;
	logic [4:0]       in_col;
	logic [3:0]       in_kidx;
	logic [SYM_W-1:0] in_sym;

	assign cmd     = cmd_t'(s_axis_tuser);
	assign in_row  = s_axis_tdata[4:0];
	assign in_col  = s_axis_tdata[9:5];
	assign in_kidx = s_axis_tdata[13:10];
	assign in_sym  = s_axis_tdata[21:14];

	state_t state_q, state_d;

	logic                 mode_q;
	logic [KEY_LEN_W-1:0] klen_q;
	logic [KPW-1:0]       kp_q;

	logic [SYM_W-1:0] tab_mem [TD];
	logic [SYM_W-1:0] key_mem [KEY_MAX];
	logic [SYM_W-1:0] hdr_q   [ALPHABET_SIZE];
	logic [SYM_W-1:0] tab_rd_q;
	logic [SYM_W-1:0] key_rd_q;

	logic [SYM_W-1:0] sym_q;
	logic             last_q;
	logic [AW-1:0]    scan_addr_q;
	logic [AW-1:0]    fetch_base_q;
	logic [RW:0]      issue_col_q;
	logic             rd_v_s1;
	logic [RW-1:0]    col_s1;

	logic             out_valid_q;
	logic [SYM_W-1:0] out_sym_q;
	logic             out_last_q;

	logic          in_fire;
	logic          tab_wr_en;
	logic [AW-1:0] tab_wr_addr;
	logic          key_wr_en;
	logic          tab_rd_en;
	logic [AW-1:0] tab_rd_addr;
	logic          scan_issue;
	logic          scan_hit;
	logic          out_load;
	logic          row_found;
	logic [RW-1:0] row_sel;
	logic [AW-1:0] row_base;

	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	// write decode
	assign tab_wr_en = in_fire && (cmd == CMD_TABLEAU)
		&& (RCW'(in_row) < RCW'(ALPHABET_SIZE)) && (RCW'(in_col) < RCW'(ALPHABET_SIZE));
	assign tab_wr_addr = AW'(AW'(RW'(in_row)) * AW'(ALPHABET_SIZE) + AW'(RW'(in_col)));
	assign key_wr_en = in_fire && (cmd == CMD_KEY) && (KCW'(in_kidx) < KCW'(KEY_MAX));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			klen_q <= KEY_LEN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MODE:    mode_q <= cfg_data[0];
				REG_KEY_LEN: klen_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	// key position: advances on each text request, wraps at the clamped key length or after tlast
	logic [KPW:0]   kp_next;
	logic [KCW-1:0] klen_eff;

	always_comb begin
		kp_next = {1'b0, kp_q} + (KPW+1)'(1);
		if (klen_q == '0)
			klen_eff = KCW'(1);
		else if (KCW'(klen_q) > KCW'(KEY_MAX))
			klen_eff = KCW'(KEY_MAX);
		else
			klen_eff = KCW'(klen_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= '0;
		end else if (in_fire && cmd == CMD_TEXT) begin
			if (s_axis_tlast || KCW'(kp_next) >= klen_eff)
				kp_q <= '0;
			else
				kp_q <= kp_next[KPW-1:0];
		end
	end

	// key memory, registered read at the current position
	always_ff @(posedge clk) begin
		if (key_wr_en)
			key_mem[KPW'(in_kidx)] <= in_sym;
		if (in_fire && cmd == CMD_TEXT)
			key_rd_q <= key_mem[kp_q];
	end

	// tableau memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (tab_wr_en)
			tab_mem[tab_wr_addr] <= in_sym;
		if (tab_rd_en)
			tab_rd_q <= tab_mem[tab_rd_addr];
	end

	// row header mirror of column 0
	always_ff @(posedge clk) begin
		if (tab_wr_en && in_col == '0)
			hdr_q[RW'(in_row)] <= in_sym;
	end

	// first row whose header equals the key byte
	always_comb begin
		row_found = 1'b0;
		row_sel   = '0;
		for (int i = ALPHABET_SIZE - 1; i >= 0; i--) begin
			if (hdr_q[i] == key_rd_q) begin
				row_found = 1'b1;
				row_sel   = RW'(i);
			end
		end
		row_base = AW'(AW'(row_sel) * AW'(ALPHABET_SIZE));
	end

	// sequencer: next state and memory read control
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		tab_rd_en     = 1'b0;
		tab_rd_addr   = scan_addr_q;
		scan_issue    = 1'b0;
		scan_hit      = rd_v_s1 && (tab_rd_q == sym_q);
		out_load      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && cmd == CMD_TEXT)
					state_d = S_KEY;
			end
			S_KEY: begin
				state_d = row_found ? S_SCAN : S_IDLE;
			end
			S_SCAN: begin
				if (scan_hit) begin
					tab_rd_en   = 1'b1;
					tab_rd_addr = AW'(fetch_base_q + AW'(col_s1));
					state_d     = S_FETCH;
				end else if (issue_col_q < (RW+1)'(ALPHABET_SIZE)) begin
					tab_rd_en  = 1'b1;
					scan_issue = 1'b1;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_FETCH: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// scan pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_v_s1 <= 1'b0;
		else
			rd_v_s1 <= scan_issue;
	end

	// request payload and scan bookkeeping
	always_ff @(posedge clk) begin
		if (in_fire && cmd == CMD_TEXT) begin
			sym_q  <= in_sym;
			last_q <= s_axis_tlast;
		end
		if (state_q == S_KEY) begin
			scan_addr_q  <= mode_q ? '0 : row_base;
			fetch_base_q <= mode_q ? row_base : '0;
			issue_col_q  <= '0;
		end else if (scan_issue) begin
			scan_addr_q <= scan_addr_q + AW'(1);
			issue_col_q <= issue_col_q + (RW+1)'(1);
			col_s1      <= issue_col_q[RW-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sym_q  <= tab_rd_q;
			out_last_q <= last_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_sym_q;
	assign m_axis_tlast  = out_last_q;

	// a text request always goes to the key lookup next
	a_text_to_key: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && cmd == CMD_TEXT) |=> state_q == S_KEY)
		else $error("text request did not start key lookup");

	// scan reads are in flight only during the scan and stay inside one row
	a_scan_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> (state_q == S_SCAN) && ((RW+1)'(col_s1) < (RW+1)'(ALPHABET_SIZE)))
		else $error("scan read outside scan state or row");

	// key position never leaves the key store
	a_kp_range: assert property (@(posedge clk) disable iff (!arst_n)
		KCW'(kp_q) < KCW'(KEY_MAX))
		else $error("key position out of range");

	// result only produced from the fetch state
	a_load_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_FETCH)
		else $error("result loaded outside fetch");

endmodule
